FILE: rtl/bfiq_pkg.sv
// Shared types, constants and codes for the bloom filter insert/query block.
// No dependencies; every other file imports this package.
package bfiq_pkg;

  localparam int HASH_W      = 32;
  localparam int PROBE_W     = 5;
  localparam int FBYTES_W    = 14;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;
  // filter bit count is at most 8 * (2^14 - 1), fits in 17 bits
  localparam int BITS_W      = FBYTES_W + 3;
  localparam int STEP_ROT    = 17;

  localparam int DEF_MAX_FILTER_BYTES = 8192;
  localparam int DEF_MAX_PROBES       = 30;

  localparam logic [FBYTES_W-1:0] MIN_FILTER_BYTES = FBYTES_W'(8);
  localparam logic [PROBE_W-1:0]  RST_PROBE_COUNT  = PROBE_W'(6);
  localparam logic [FBYTES_W-1:0] RST_FILTER_BYTES = FBYTES_W'(8192);

  // remainder unit retires two dividend bits per cycle
  localparam int REM_STEPS = HASH_W / 2;
  localparam int REM_CNT_W = $clog2(REM_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBE_COUNT  = 1'b0,
    CFG_FILTER_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_HMOD,
    S_SMOD,
    S_RD,
    S_UPD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [BITS_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BITS_W-1:0] rem;
  } rem_rsp_t;

endpackage

FILE: rtl/bfiq_if.sv
// Valid/ready channel interfaces for the insert/query items and the results.
// Depends on bfiq_pkg for field widths.
interface bfiq_in_if import bfiq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [HASH_W-1:0] key_hash;

  modport source (output valid, output action, output key_hash, input ready);
  modport sink   (input valid, input action, input key_hash, output ready);
endinterface

interface bfiq_out_if import bfiq_pkg::*; ();
  logic valid;
  logic ready;
  logic may_match;

  modport source (output valid, output may_match, input ready);
  modport sink   (input valid, input may_match, output ready);
endinterface

FILE: rtl/bfiq_rem_unit.sv
// Iterative remainder unit: 32-bit dividend modulo a 17-bit divisor,
// two restoring steps per cycle. Depends on bfiq_pkg.
module bfiq_rem_unit import bfiq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [REM_CNT_W-1:0] cnt_q, cnt_d;
  logic [HASH_W-1:0]    dvd_q;
  logic [BITS_W-1:0]    dvs_q;
  logic [BITS_W-1:0]    rem_q;
  logic [BITS_W:0]      r1, r2;
  logic [BITS_W-1:0]    r1_red, r2_red;

  always_comb begin
    r1 = {rem_q, dvd_q[HASH_W-1]};
    if (r1 >= {1'b0, dvs_q}) begin
      r1 = r1 - {1'b0, dvs_q};
    end
    r1_red = r1[BITS_W-1:0];
    r2 = {r1_red, dvd_q[HASH_W-2]};
    if (r2 >= {1'b0, dvs_q}) begin
      r2 = r2 - {1'b0, dvs_q};
    end
    r2_red = r2[BITS_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 2;
      rem_q <= r2_red;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/bfiq_store.sv
// Filter bit store: byte-wide single-port memory with registered read and
// a zeroing sweep after reset. Depends on bfiq_pkg.
module bfiq_store import bfiq_pkg::*; #(
  parameter int Depth = DEF_MAX_FILTER_BYTES,
  localparam int AW   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o,
  output logic          ready_o
);

  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;
  logic [AW:0]   clr_q, clr_d;
  logic          clearing;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  assign clearing = (clr_q != (AW+1)'(Depth));

  always_comb begin
    clr_d = clr_q;
    if (clearing) begin
      clr_d = clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_comb begin
    we    = clearing | wr_en_i;
    waddr = clearing ? clr_q[AW-1:0] : addr_i;
    wdata = clearing ? 8'h00 : wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clearing;

endmodule

FILE: rtl/bloom_filter_insert_query.sv
// Bloom filter insert/query with double hashing over a 32-bit key hash.
// After reset the store is zeroed in a sweep over all MAX_FILTER_BYTES
// bytes before the first item is taken. An item then finds hash mod B and
// step mod B in the shared remainder unit (two bits per cycle), then does
// one read and one update per probe on the single memory port; the update
// writes the bit back on insert and tests it on query. The first item after
// reset or after a filter_bytes write first finds 2^32 mod B in the unit.
// Depends on bfiq_pkg, bfiq_if, bfiq_rem_unit and bfiq_store.
module bloom_filter_insert_query import bfiq_pkg::*; #(
  parameter int MAX_FILTER_BYTES = DEF_MAX_FILTER_BYTES,
  parameter int MAX_PROBES       = DEF_MAX_PROBES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bfiq_in_if.sink               in_if,
  bfiq_out_if.source            out_if
);

  localparam int AW = $clog2(MAX_FILTER_BYTES);

  state_e              state_q, state_d;
  logic [PROBE_W-1:0]  probe_count_q;
  logic [FBYTES_W-1:0] filter_bytes_q;
  logic                action_q;
  logic [HASH_W-1:0]   h_q, step_q;
  logic [BITS_W-1:0]   pos_q, smod_q, w_q;
  logic                w_valid_q;
  logic                carry_q;
  logic [2:0]          bsel_q;
  logic [AW-1:0]       addr_q;
  logic [PROBE_W-1:0]  pcnt_q;
  logic                all_set_q;
  logic                out_valid_q;
  logic                may_match_q;

  logic [FBYTES_W-1:0] eff_bytes;
  logic [BITS_W-1:0]   bits;
  logic [PROBE_W-1:0]  eff_k;
  logic                in_acc;
  logic                last_probe;
  logic                res_load;
  logic [HASH_W-1:0]   in_step;
  logic [HASH_W:0]     h_sum;
  logic [BITS_W:0]     p_sum;
  logic [BITS_W-1:0]   p_next;
  logic [BITS_W-1:0]   p_fix;
  logic [BITS_W-1:0]   wrap_rem;

  rem_req_t            rem_req;
  rem_rsp_t            rem_rsp;
  logic                st_rd, st_wr, st_ready;
  logic [AW-1:0]       st_addr;
  logic [7:0]          st_wdata, st_rdata;

  // clamped geometry and probe count
  always_comb begin
    eff_bytes = filter_bytes_q;
    if (filter_bytes_q < MIN_FILTER_BYTES) begin
      eff_bytes = MIN_FILTER_BYTES;
    end
    if (32'(filter_bytes_q) > MAX_FILTER_BYTES) begin
      eff_bytes = FBYTES_W'(MAX_FILTER_BYTES);
    end
    bits  = {eff_bytes, 3'b000};
    eff_k = probe_count_q;
    if (probe_count_q == '0) begin
      eff_k = PROBE_W'(1);
    end
    if (probe_count_q > PROBE_W'(MAX_PROBES)) begin
      eff_k = PROBE_W'(MAX_PROBES);
    end
  end

  assign in_acc     = in_if.valid & in_if.ready;
  assign last_probe = (pcnt_q == eff_k - 1'b1);
  assign res_load   = (state_q == S_DONE) & (!out_valid_q | out_if.ready);
  assign in_step    = (in_if.key_hash >> STEP_ROT) | (in_if.key_hash << (HASH_W - STEP_ROT));

  // next probe position: add step mod B, then undo the 2^32 wrap of h
  always_comb begin
    h_sum = {1'b0, h_q} + {1'b0, step_q};
    p_sum = {1'b0, pos_q} + {1'b0, smod_q};
    if (p_sum >= {1'b0, bits}) begin
      p_sum = p_sum - {1'b0, bits};
    end
    p_next = p_sum[BITS_W-1:0];
    if (pos_q >= w_q) begin
      p_fix = pos_q - w_q;
    end else begin
      p_fix = pos_q + (bits - w_q);
    end
    // (2^32 - 1) mod B, plus one, reduced
    wrap_rem = rem_rsp.rem + 1'b1;
    if (wrap_rem == bits) begin
      wrap_rem = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (st_ready) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = w_valid_q ? S_HMOD : S_WRAP;
      end
      S_WRAP: begin
        if (rem_rsp.done) state_d = S_HMOD;
      end
      S_HMOD: begin
        if (rem_rsp.done) state_d = S_SMOD;
      end
      S_SMOD: begin
        if (rem_rsp.done) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        state_d = last_probe ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (res_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    rem_req.start    = 1'b0;
    rem_req.dividend = h_q;
    rem_req.divisor  = bits;
    st_rd            = 1'b0;
    st_wr            = 1'b0;
    st_addr          = addr_q;
    st_wdata         = st_rdata | (8'h01 << bsel_q);
    case (state_q)
      S_IDLE: begin
        rem_req.start    = in_acc;
        rem_req.dividend = w_valid_q ? in_if.key_hash : '1;
      end
      S_WRAP: begin
        rem_req.start = rem_rsp.done;
      end
      S_HMOD: begin
        rem_req.start    = rem_rsp.done;
        rem_req.dividend = step_q;
      end
      S_RD: begin
        st_rd   = 1'b1;
        st_addr = AW'(pos_q >> 3);
      end
      S_UPD: begin
        st_wr = (action_q == ACT_INSERT);
      end
      default: begin
      end
    endcase
  end

  assign in_if.ready      = (state_q == S_IDLE);
  assign out_if.valid     = out_valid_q;
  assign out_if.may_match = may_match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      probe_count_q  <= RST_PROBE_COUNT;
      filter_bytes_q <= RST_FILTER_BYTES;
      w_valid_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROBE_COUNT: probe_count_q <= cfg_wdata_i[PROBE_W-1:0];
          CFG_FILTER_BYTES: begin
            filter_bytes_q <= cfg_wdata_i[FBYTES_W-1:0];
            w_valid_q      <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state_q == S_WRAP && rem_rsp.done) begin
        w_valid_q <= 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q  <= in_if.action;
      h_q       <= in_if.key_hash;
      step_q    <= in_step;
      pcnt_q    <= '0;
      all_set_q <= 1'b1;
    end
    if (state_q == S_WRAP && rem_rsp.done) begin
      w_q <= wrap_rem;
    end
    if (state_q == S_HMOD && rem_rsp.done) begin
      pos_q <= rem_rsp.rem;
    end
    if (state_q == S_SMOD && rem_rsp.done) begin
      smod_q <= rem_rsp.rem;
    end
    if (state_q == S_RD) begin
      addr_q  <= AW'(pos_q >> 3);
      bsel_q  <= pos_q[2:0];
      h_q     <= h_sum[HASH_W-1:0];
      carry_q <= h_sum[HASH_W];
      pos_q   <= p_next;
    end
    if (state_q == S_UPD) begin
      pcnt_q <= pcnt_q + 1'b1;
      if (carry_q) begin
        pos_q <= p_fix;
      end
      if (action_q == ACT_QUERY && !st_rdata[bsel_q]) begin
        all_set_q <= 1'b0;
      end
    end
    if (res_load) begin
      may_match_q <= (action_q == ACT_QUERY) & all_set_q;
    end
  end

  bfiq_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  bfiq_store #(
    .Depth (MAX_FILTER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (st_rd),
    .wr_en_i (st_wr),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata),
    .ready_o (st_ready)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_WRAP || state_q == S_HMOD))
    else $error("accepted item did not start the remainder unit");

  a_rem_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_req.start |-> !rem_rsp.busy)
    else $error("remainder unit restarted while busy");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (pos_q < bits))
    else $error("probe position outside the filter");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (pcnt_q < eff_k))
    else $error("probe count overran");
`endif

endmodule

FILE: sim/tb_bloom_filter_insert_query.sv
// Testbench for bloom_filter_insert_query: directed and random insert/query items,
// checked against a bit-level filter predictor kept in the bench.
// Depends on bfiq_pkg, bfiq_if and the RTL of the block.
module tb_bloom_filter_insert_query;
  import bfiq_pkg::*;

  typedef struct {
    action_e     act;
    logic [31:0] hash;
  } key_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_PROBE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic drv_valid = 1'b0;
  logic drv_act = 1'b0;
  logic [HASH_W-1:0] drv_hash = '0;
  logic rcv_ready = 1'b0;

  bfiq_in_if  in_ch ();
  bfiq_out_if out_ch ();

  assign in_ch.valid    = drv_valid;
  assign in_ch.action   = drv_act;
  assign in_ch.key_hash = drv_hash;
  assign out_ch.ready   = rcv_ready;

  bloom_filter_insert_query DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #4 clk = ~clk;

  // predictor state: flat bit view of the filter plus register copies
  bit [0:DEF_MAX_FILTER_BYTES*8-1] flt_bits;
  bit [PROBE_W-1:0]  cur_probes = RST_PROBE_COUNT;
  bit [FBYTES_W-1:0] cur_bytes  = RST_FILTER_BYTES;

  key_item_t   key_pend_q[$];
  bit          match_q[$];
  logic [31:0] inserted_keys[$];
  int          n_sent = 0;
  int          n_done = 0;
  int          err_cnt = 0;

  int gap_left = 0;
  int burst_left = 0;
  bit [31:0] stall_pat = '1;
  int stall_left = 0;

  // walks the probe sequence; sets bits on insert, tests them on query
  function automatic bit probe_filter(action_e act, logic [31:0] key);
    int unsigned k, nb, nbits, pos;
    bit [31:0] h, step;
    bit all_set;
    int j;
    k = cur_probes;
    if (k < 1) k = 1;
    if (k > DEF_MAX_PROBES) k = DEF_MAX_PROBES;
    nb = cur_bytes;
    if (nb < MIN_FILTER_BYTES) nb = MIN_FILTER_BYTES;
    if (nb > DEF_MAX_FILTER_BYTES) nb = DEF_MAX_FILTER_BYTES;
    nbits = nb * 8;
    h = key;
    step = {h[16:0], h[31:17]};
    all_set = 1'b1;
    for (j = 0; j < k; j++) begin
      pos = h % nbits;
      if (act == ACT_QUERY) begin
        if (!flt_bits[pos]) all_set = 1'b0;
      end else begin
        flt_bits[pos] = 1'b1;
      end
      h = h + step;
    end
    return (act == ACT_QUERY) && all_set;
  endfunction

  // driver: bursts of items with random gaps between bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (drv_valid && in_ch.ready) begin
        match_q.push_back(probe_filter(action_e'(drv_act), drv_hash));
      end
      if (!drv_valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (key_pend_q.size() > 0) begin
          key_item_t it;
          it = key_pend_q.pop_front();
          drv_valid <= 1'b1;
          drv_act   <= it.act;
          drv_hash  <= it.hash;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result checks and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && rcv_ready) begin
        if (match_q.size() == 0) begin
          $error("may_match: unexpected result, actual %0b", out_ch.may_match);
          err_cnt++;
        end else begin
          bit exp_match;
          exp_match = match_q.pop_front();
          if (out_ch.may_match !== exp_match) begin
            $error("may_match mismatch: expected %0b, actual %0b", exp_match,
                   out_ch.may_match);
            err_cnt++;
          end
        end
        n_done++;
      end
      if (stall_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
        stall_left = 32;
      end
      rcv_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      stall_left--;
    end
  end

  task automatic push_key(action_e act, logic [31:0] key);
    key_item_t it;
    it.act = act;
    it.hash = key;
    key_pend_q.push_back(it);
    n_sent++;
    if (act == ACT_INSERT) inserted_keys.push_back(key);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_done != n_sent);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROBE_COUNT) cur_probes = val[PROBE_W-1:0];
    else cur_bytes = val;
    @(negedge clk);
  endtask

  task automatic random_keys(int n);
    int r, i;
    logic [31:0] key;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0: key = $urandom_range(0, 255);
        1: key = ~32'($urandom_range(0, 255));
        default: key = $urandom;
      endcase
      if (r < 45) begin
        push_key(ACT_INSERT, key);
      end else if (r < 75 && inserted_keys.size() > 0) begin
        push_key(ACT_QUERY, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
      end else begin
        push_key(ACT_QUERY, key);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, hash extremes
    push_key(ACT_INSERT, 32'h0000_0000);
    push_key(ACT_QUERY,  32'h0000_0000);
    push_key(ACT_QUERY,  32'hFFFF_FFFF);
    push_key(ACT_INSERT, 32'hFFFF_FFFF);
    push_key(ACT_QUERY,  32'hFFFF_FFFF);
    push_key(ACT_QUERY,  32'h1234_5678);
    push_key(ACT_INSERT, 32'h8000_0000);
    push_key(ACT_QUERY,  32'h8000_0000);
    push_key(ACT_QUERY,  32'h0001_0000);
    wait_idle();

    // zero probe count runs one probe, short length clamps to 8 bytes
    write_cfg(CFG_PROBE_COUNT, 14'h3FE0);
    write_cfg(CFG_FILTER_BYTES, 14'h0000);
    push_key(ACT_INSERT, 32'hA5A5_A5A5);
    push_key(ACT_QUERY,  32'hA5A5_A5A5);
    push_key(ACT_QUERY,  32'h5A5A_5A5A);
    wait_idle();

    // probe count above max clamps to 30, oversized length clamps to max
    write_cfg(CFG_PROBE_COUNT, 14'h3FFF);
    write_cfg(CFG_FILTER_BYTES, 14'h3FFF);
    push_key(ACT_QUERY,  32'h0000_0000);
    push_key(ACT_INSERT, 32'hDEAD_BEEF);
    push_key(ACT_QUERY,  32'hDEAD_BEEF);
    wait_idle();

    // length change keeps the stored bits
    write_cfg(CFG_FILTER_BYTES, 14'd8);
    push_key(ACT_QUERY, 32'hDEAD_BEEF);
    push_key(ACT_QUERY, 32'h0000_0000);
    wait_idle();
    write_cfg(CFG_FILTER_BYTES, 14'd8192);
    push_key(ACT_QUERY, 32'hDEAD_BEEF);
    wait_idle();

    write_cfg(CFG_PROBE_COUNT, 14'd1);
    random_keys(100);

    write_cfg(CFG_PROBE_COUNT, 14'd30);
    write_cfg(CFG_FILTER_BYTES, 14'd8);
    random_keys(80);

    write_cfg(CFG_PROBE_COUNT, 14'h3FFF);
    write_cfg(CFG_FILTER_BYTES, 14'h3FFF);
    random_keys(100);

    write_cfg(CFG_PROBE_COUNT, 14'($urandom_range(1, 30)));
    write_cfg(CFG_FILTER_BYTES, 14'($urandom_range(8, 8192)));
    random_keys(110);

    write_cfg(CFG_PROBE_COUNT, 14'h3FE0);
    write_cfg(CFG_FILTER_BYTES, 14'($urandom_range(0, 7)));
    random_keys(80);

    write_cfg(CFG_PROBE_COUNT, 14'($urandom_range(1, 30)));
    write_cfg(CFG_FILTER_BYTES, 14'($urandom_range(9, 200)));
    random_keys(110);

    write_cfg(CFG_PROBE_COUNT, 14'd15);
    write_cfg(CFG_FILTER_BYTES, 14'd5000);
    random_keys(120);

    // drain: catch any stray result after the last expected one
    repeat (150) @(posedge clk);
    if (err_cnt == 0 && match_q.size() == 0) begin
      $display("PASS bloom_filter_insert_query");
    end else begin
      $display("FAIL bloom_filter_insert_query");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("FAIL bloom_filter_insert_query");
    $finish;
  end

endmodule
